@@ hdl/m4i_pkg.sv @@
// shared types, constants and cofactor tables of the 4x4 matrix inverse
`timescale 1ns / 1ps
`default_nettype none
package m4i_pkg;

  localparam int WORD_W = 32;
  localparam int IDX_W  = 4;
  localparam logic [IDX_W-1:0] MAT_LAST = 4'd15;

  // default quiet nan produced by invalid operations
  localparam logic [WORD_W-1:0] QNAN     = 32'hFFC0_0000;
  localparam logic [WORD_W-1:0] QBIT     = 32'h0040_0000;
  localparam logic [30:0]       INF_MAG  = 31'h7F80_0000;

  // sign of the leading term of each cofactor, one bit per cofactor
  localparam logic [15:0] COF_NEG = 16'h5A5A;
  // terms subtracted when the leading term is positive
  localparam logic [5:0]  SUB_PAT = 6'b100110;

  typedef enum logic [1:0] {
    FOP_MUL,
    FOP_ADD,
    FOP_SUB,
    FOP_RCP
  } fop_t;

  typedef struct packed {
    logic              start;
    fop_t              op;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } fpu_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [WORD_W-1:0] res;
  } fpu_rsp_t;

  // element index of one factor: six terms of three factors per cofactor
  function automatic logic [3:0] cof_pick(input logic [3:0] k, input logic [4:0] slot);
    logic [71:0] row;
    logic [71:0] sh;
    case (k)
      4'd0:    row = 72'h5AF5BE96F97ED6BD7A;
      4'd1:    row = 72'h1AF1BE92F93ED2BD3A;
      4'd2:    row = 72'h16F17E52F53ED27D36;
      4'd3:    row = 72'h16B17A52B53A927936;
      4'd4:    row = 72'h4AF4BE86F87EC6BC7A;
      4'd5:    row = 72'h0AF0BE82F83EC2BC3A;
      4'd6:    row = 72'h06F07E42F43EC27C36;
      4'd7:    row = 72'h06B07A42B43A827836;
      4'd8:    row = 72'h49F4BD85F87DC5BC79;
      4'd9:    row = 72'h09F0BD81F83DC1BC39;
      4'd10:   row = 72'h05F07D41F43DC17C35;
      4'd11:   row = 72'h05B07941B439817835;
      4'd12:   row = 72'h49E4AD85E86DC5AC69;
      4'd13:   row = 72'h09E0AD81E82DC1AC29;
      4'd14:   row = 72'h05E06D41E42DC16C25;
      4'd15:   row = 72'h05A06941A429816825;
      default: row = '0;
    endcase
    sh = row << {slot, 2'b00};
    return sh[71:68];
  endfunction

endpackage
`default_nettype wire

@@ hdl/m4i_if.sv @@
// item channel interfaces of the 4x4 matrix inverse
`timescale 1ns / 1ps
`default_nettype none
interface m4i_in_if;
  logic                        valid;
  logic                        ready;
  logic [m4i_pkg::WORD_W-1:0]  element_bits;
  logic [m4i_pkg::IDX_W-1:0]   element_index;
  modport source (output valid, output element_bits, output element_index, input ready);
  modport sink   (input valid, input element_bits, input element_index, output ready);
endinterface

interface m4i_out_if;
  logic                        valid;
  logic                        ready;
  logic [m4i_pkg::WORD_W-1:0]  result_bits;
  logic [m4i_pkg::IDX_W-1:0]   result_index;
  logic                        singular;
  logic                        last;
  modport source (output valid, output result_bits, output result_index, output singular,
                  output last, input ready);
  modport sink   (input valid, input result_bits, input result_index, input singular,
                  input last, output ready);
endinterface
`default_nettype wire

@@ hdl/m4i_fpu.sv @@
// shared binary32 unit: multiply, add, subtract, reciprocal, round to nearest even
`timescale 1ns / 1ps
`default_nettype none
module m4i_fpu (
  input  wire                clk,
  input  wire                rst_n,
  input  m4i_pkg::fpu_req_t  req,
  output m4i_pkg::fpu_rsp_t  rsp
);

  typedef enum logic [2:0] {
    F_IDLE,
    F_DIV,
    F_LZC,
    F_SHIFT,
    F_ROUND
  } f_state_t;

  f_state_t           state_r;
  logic               done_r;
  logic [31:0]        res_r;
  logic [51:0]        sig_r;
  logic signed [10:0] x_r;
  logic               sign_r;
  logic               zsign_r;
  logic [23:0]        rem_r;
  logic [50:0]        q_r;
  logic [23:0]        mb_r;
  logic [5:0]         cnt_r;
  logic [6:0]         s_r;
  logic signed [10:0] l_r;
  logic [24:0]        kept_r;
  logic               guard_r;
  logic               sticky_r;

  // highest set bit of the raw significand
  function automatic logic [5:0] msb_pos(input logic [51:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 52; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

  // operand unpacking
  logic               sa, sb, sbe;
  logic [7:0]         ea, eb;
  logic [22:0]        fa, fb;
  logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [23:0]        ma, mb;
  logic signed [10:0] exa, exb;

  always_comb begin
    sa     = req.a[31];
    sb     = req.b[31];
    sbe    = req.b[31] ^ (req.op == m4i_pkg::FOP_SUB);
    ea     = req.a[30:23];
    eb     = req.b[30:23];
    fa     = req.a[22:0];
    fb     = req.b[22:0];
    a_nan  = (ea == 8'hFF) && (fa != '0);
    b_nan  = (eb == 8'hFF) && (fb != '0);
    a_inf  = (ea == 8'hFF) && (fa == '0);
    b_inf  = (eb == 8'hFF) && (fb == '0);
    a_zero = (req.a[30:0] == '0);
    b_zero = (req.b[30:0] == '0);
    ma     = {ea != 8'd0, fa};
    mb     = {eb != 8'd0, fb};
    exa    = (ea == 8'd0) ? -11'sd126 : $signed({3'b000, ea}) - 11'sd127;
    exb    = (eb == 8'd0) ? -11'sd126 : $signed({3'b000, eb}) - 11'sd127;
  end

  // raw product and aligned sum
  logic [47:0]        prod;
  logic               a_big;
  logic [23:0]        m_big, m_sml;
  logic signed [10:0] ex_big, ex_sml, dexp;
  logic               s_big, s_sml;
  logic [26:0]        a27, b27, bs27;
  logic [27:0]        sum28;
  logic               sum_sign;

  always_comb begin
    prod   = ma * mb;
    a_big  = exa >= exb;
    m_big  = a_big ? ma : mb;
    m_sml  = a_big ? mb : ma;
    ex_big = a_big ? exa : exb;
    ex_sml = a_big ? exb : exa;
    s_big  = a_big ? sa : sbe;
    s_sml  = a_big ? sbe : sa;
    dexp   = ex_big - ex_sml;
    a27    = {m_big, 3'b000};
    b27    = {m_sml, 3'b000};
    if (dexp >= 11'sd27) begin
      bs27 = {26'd0, m_sml != '0};
    end else begin
      bs27 = (b27 >> dexp[4:0]) | {26'd0, (b27 & ~(27'h7FF_FFFF << dexp[4:0])) != '0};
    end
    if (s_big == s_sml) begin
      sum28    = {1'b0, a27} + {1'b0, bs27};
      sum_sign = s_big;
    end else if (a27 >= bs27) begin
      sum28    = {1'b0, a27} - {1'b0, bs27};
      sum_sign = s_big;
    end else begin
      sum28    = {1'b0, bs27} - {1'b0, a27};
      sum_sign = s_sml;
    end
  end

  // nan, infinity and zero operands
  logic        spec_hit;
  logic [31:0] spec_res;

  always_comb begin
    spec_hit = 1'b1;
    spec_res = '0;
    case (req.op)
      m4i_pkg::FOP_MUL: begin
        if (a_nan)                                  spec_res = req.a | m4i_pkg::QBIT;
        else if (b_nan)                             spec_res = req.b | m4i_pkg::QBIT;
        else if ((a_inf && b_zero) || (a_zero && b_inf)) spec_res = m4i_pkg::QNAN;
        else if (a_inf || b_inf)                    spec_res = {sa ^ sb, m4i_pkg::INF_MAG};
        else if (a_zero || b_zero)                  spec_res = {sa ^ sb, 31'd0};
        else                                        spec_hit = 1'b0;
      end
      m4i_pkg::FOP_ADD, m4i_pkg::FOP_SUB: begin
        if (a_nan)                                  spec_res = req.a | m4i_pkg::QBIT;
        else if (b_nan)                             spec_res = req.b | m4i_pkg::QBIT;
        else if (a_inf && b_inf && (sa != sbe))     spec_res = m4i_pkg::QNAN;
        else if (a_inf)                             spec_res = req.a;
        else if (b_inf)                             spec_res = {sbe, req.b[30:0]};
        else if (a_zero && b_zero)                  spec_res = {sa & sbe, 31'd0};
        else                                        spec_hit = 1'b0;
      end
      m4i_pkg::FOP_RCP: begin
        if (b_nan)                                  spec_res = req.b | m4i_pkg::QBIT;
        else if (b_inf)                             spec_res = {sb, 31'd0};
        else if (b_zero)                            spec_res = {sb, m4i_pkg::INF_MAG};
        else                                        spec_hit = 1'b0;
      end
      default: spec_hit = 1'b0;
    endcase
  end

  // one restoring division step on the reciprocal
  logic [24:0] rem2;
  logic        q_bit;
  logic [23:0] rem_nxt;
  logic [50:0] q_nxt;

  always_comb begin
    rem2    = {rem_r, cnt_r == 6'd50};
    q_bit   = rem2 >= {1'b0, mb_r};
    rem_nxt = q_bit ? 24'(rem2 - {1'b0, mb_r}) : rem2[23:0];
    q_nxt   = {q_r[49:0], q_bit};
  end

  // exponent of the leading bit and the shift that places the lsb
  logic [5:0]         lead;
  logic signed [10:0] e_lead, l_lsb, s_full;
  logic [6:0]         s_sat;

  always_comb begin
    lead   = msb_pos(sig_r);
    e_lead = x_r + $signed({5'd0, lead});
    l_lsb  = (e_lead - 11'sd23 > -11'sd149) ? e_lead - 11'sd23 : -11'sd149;
    s_full = l_lsb - x_r + 11'sd24;
    s_sat  = (s_full > 11'sd100) ? 7'd100 : s_full[6:0];
  end

  // alignment with guard and sticky
  logic [75:0] v76, sh76;
  logic [6:0]  shamt;
  logic        sticky_c;

  always_comb begin
    v76      = {sig_r, 24'd0};
    shamt    = s_r - 7'd1;
    sh76     = v76 >> shamt;
    sticky_c = (v76 & ~({76{1'b1}} << shamt)) != '0;
  end

  // rounding and packing
  logic        inc;
  logic [24:0] mant;
  logic [32:0] packed_t;
  logic [9:0]  bexp;

  always_comb begin
    inc      = guard_r & (sticky_r | kept_r[0]);
    mant     = kept_r + {24'd0, inc};
    bexp     = 10'(l_r + 11'sd149);
    packed_t = {bexp, 23'd0} + {8'd0, mant};
  end

  // sequencing of one operation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        F_IDLE: begin
          if (req.start) begin
            if (spec_hit) begin
              res_r  <= spec_res;
              done_r <= 1'b1;
            end else begin
              case (req.op)
                m4i_pkg::FOP_MUL: begin
                  sig_r   <= {4'd0, prod};
                  x_r     <= exa + exb - 11'sd46;
                  sign_r  <= sa ^ sb;
                  zsign_r <= sa ^ sb;
                  state_r <= F_LZC;
                end
                m4i_pkg::FOP_RCP: begin
                  mb_r    <= mb;
                  rem_r   <= '0;
                  q_r     <= '0;
                  cnt_r   <= 6'd50;
                  x_r     <= -11'sd28 - exb;
                  sign_r  <= sb;
                  zsign_r <= sb;
                  state_r <= F_DIV;
                end
                default: begin
                  sig_r   <= {24'd0, sum28};
                  x_r     <= ex_big - 11'sd26;
                  sign_r  <= sum_sign;
                  zsign_r <= 1'b0;
                  state_r <= F_LZC;
                end
              endcase
            end
          end
        end
        F_DIV: begin
          rem_r <= rem_nxt;
          q_r   <= q_nxt;
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd0) begin
            sig_r   <= {q_nxt, rem_nxt != '0};
            state_r <= F_LZC;
          end
        end
        F_LZC: begin
          if (sig_r == '0) begin
            res_r   <= {zsign_r, 31'd0};
            done_r  <= 1'b1;
            state_r <= F_IDLE;
          end else begin
            l_r     <= l_lsb;
            s_r     <= s_sat;
            state_r <= F_SHIFT;
          end
        end
        F_SHIFT: begin
          guard_r  <= sh76[0];
          kept_r   <= sh76[25:1];
          sticky_r <= sticky_c;
          state_r  <= F_ROUND;
        end
        F_ROUND: begin
          if (packed_t >= 33'h0_7F80_0000) begin
            res_r <= {sign_r, m4i_pkg::INF_MAG};
          end else begin
            res_r <= {sign_r, packed_t[30:0]};
          end
          done_r  <= 1'b1;
          state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  assign rsp.busy = (state_r != F_IDLE);
  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule
`default_nettype wire

@@ hdl/matrix4x4_inverse.sv @@
// top level: element store, cofactor store and the inversion sequencer
//
//  channel  dir  handshake         payload
//  in_ch    in   valid / ready     element_bits, element_index
//  out_ch   out  valid / ready     result_bits, result_index, singular, last
//
// an element with index 0 to 14 is stored; index 15 starts an inversion
// whose length is set by the one shared float unit (shorter when singular or
// when an operand is zero, infinite or nan) and one read a cycle from each
// store. the input is not ready while an inversion runs.
// reset is synchronous; the stores hold no reset value.
// a stalled output holds the sequencer at the next result until taken.
`timescale 1ns / 1ps
`default_nettype none
module matrix4x4_inverse (
  input  wire         clk,
  input  wire         rst_n,
  m4i_in_if.sink      in_ch,
  m4i_out_if.source   out_ch
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_TA, S_TB, S_TC, S_TD, S_M1W, S_M2S, S_M2W, S_ADS, S_ADW,
    S_DRD, S_DLD, S_DMS, S_DMW, S_DAS, S_DAW,
    S_CHK, S_SING, S_RCPW,
    S_ORD, S_OLD, S_OMS, S_OMW, S_OPUSH
  } state_t;

  state_t      state_r;
  logic [3:0]  k_r;
  logic [2:0]  j_r;
  logic [3:0]  i_r;
  logic [31:0] op_a_r, op_b_r, op_c_r, acc_r, rcp_r;
  logic        out_valid_r;
  logic [31:0] out_bits_r;
  logic [3:0]  out_idx_r;
  logic        out_sing_r;
  logic        out_last_r;

  logic [31:0] mat_mem [16];
  logic [31:0] cof_mem [16];
  logic [31:0] mat_rd_r, cof_rd_r;
  logic        mat_re, cof_re, cof_we;
  logic [3:0]  mat_ra, cof_ra;

  m4i_pkg::fpu_req_t fpu_req;
  m4i_pkg::fpu_rsp_t fpu_rsp;

  logic in_acc;
  logic out_free;
  logic out_load;
  logic neg_k;
  logic last_term;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign out_load  = ((state_r == S_SING) || (state_r == S_OPUSH)) && out_free;
  assign neg_k     = m4i_pkg::COF_NEG[k_r];
  assign last_term = (j_r == 3'd5);

  // store addressing and float unit requests
  always_comb begin
    mat_re  = 1'b0;
    mat_ra  = '0;
    cof_re  = 1'b0;
    cof_ra  = '0;
    cof_we  = (state_r == S_ADW) && fpu_rsp.done && last_term;
    fpu_req = '{start: 1'b0, op: m4i_pkg::FOP_MUL, a: op_a_r, b: op_b_r};
    case (state_r)
      S_TA: begin
        mat_re = 1'b1;
        mat_ra = m4i_pkg::cof_pick(k_r, 5'({2'b00, j_r} * 5'd3));
      end
      S_TB: begin
        mat_re = 1'b1;
        mat_ra = m4i_pkg::cof_pick(k_r, 5'({2'b00, j_r} * 5'd3 + 5'd1));
      end
      S_TC: begin
        mat_re = 1'b1;
        mat_ra = m4i_pkg::cof_pick(k_r, 5'({2'b00, j_r} * 5'd3 + 5'd2));
      end
      S_TD, S_M2S, S_DMS, S_OMS: fpu_req.start = 1'b1;
      S_ADS: begin
        fpu_req.start = 1'b1;
        fpu_req.op    = (m4i_pkg::SUB_PAT[j_r] ^ neg_k) ? m4i_pkg::FOP_SUB
                                                         : m4i_pkg::FOP_ADD;
      end
      S_DAS: begin
        fpu_req.start = 1'b1;
        fpu_req.op    = m4i_pkg::FOP_ADD;
      end
      S_DRD: begin
        mat_re = 1'b1;
        mat_ra = {2'b00, i_r[1:0]};
        cof_re = 1'b1;
        cof_ra = {i_r[1:0], 2'b00};
      end
      S_CHK: begin
        fpu_req.start = (acc_r[30:0] != '0);
        fpu_req.op    = m4i_pkg::FOP_RCP;
        fpu_req.b     = acc_r;
      end
      S_ORD: begin
        cof_re = 1'b1;
        cof_ra = i_r;
      end
      default: ;
    endcase
  end

  // element store
  always_ff @(posedge clk) begin
    if (in_acc) mat_mem[in_ch.element_index] <= in_ch.element_bits;
    if (mat_re) mat_rd_r <= mat_mem[mat_ra];
  end

  // cofactor store
  always_ff @(posedge clk) begin
    if (cof_we) cof_mem[k_r] <= fpu_rsp.res;
    if (cof_re) cof_rd_r <= cof_mem[cof_ra];
  end

  m4i_fpu u_fpu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (fpu_req),
    .rsp   (fpu_rsp)
  );

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_acc && (in_ch.element_index == m4i_pkg::MAT_LAST)) begin
            k_r     <= '0;
            j_r     <= '0;
            state_r <= S_TA;
          end
        end
        S_TA: state_r <= S_TB;
        S_TB: begin
          op_a_r  <= {mat_rd_r[31] ^ ((j_r == 3'd0) && neg_k), mat_rd_r[30:0]};
          state_r <= S_TC;
        end
        S_TC: begin
          op_b_r  <= mat_rd_r;
          state_r <= S_TD;
        end
        S_TD: begin
          op_c_r  <= mat_rd_r;
          state_r <= S_M1W;
        end
        S_M1W: begin
          if (fpu_rsp.done) begin
            op_a_r  <= fpu_rsp.res;
            op_b_r  <= op_c_r;
            state_r <= S_M2S;
          end
        end
        S_M2S: state_r <= S_M2W;
        S_M2W: begin
          if (fpu_rsp.done) begin
            if (j_r == 3'd0) begin
              acc_r   <= fpu_rsp.res;
              j_r     <= 3'd1;
              state_r <= S_TA;
            end else begin
              op_a_r  <= acc_r;
              op_b_r  <= fpu_rsp.res;
              state_r <= S_ADS;
            end
          end
        end
        S_ADS: state_r <= S_ADW;
        S_ADW: begin
          if (fpu_rsp.done) begin
            acc_r <= fpu_rsp.res;
            if (last_term) begin
              j_r <= '0;
              if (k_r == m4i_pkg::MAT_LAST) begin
                i_r     <= '0;
                state_r <= S_DRD;
              end else begin
                k_r     <= k_r + 4'd1;
                state_r <= S_TA;
              end
            end else begin
              j_r     <= j_r + 3'd1;
              state_r <= S_TA;
            end
          end
        end
        // determinant along the first row
        S_DRD: state_r <= S_DLD;
        S_DLD: begin
          op_a_r  <= mat_rd_r;
          op_b_r  <= cof_rd_r;
          state_r <= S_DMS;
        end
        S_DMS: state_r <= S_DMW;
        S_DMW: begin
          if (fpu_rsp.done) begin
            if (i_r == 4'd0) begin
              acc_r   <= fpu_rsp.res;
              i_r     <= 4'd1;
              state_r <= S_DRD;
            end else begin
              op_a_r  <= acc_r;
              op_b_r  <= fpu_rsp.res;
              state_r <= S_DAS;
            end
          end
        end
        S_DAS: state_r <= S_DAW;
        S_DAW: begin
          if (fpu_rsp.done) begin
            acc_r <= fpu_rsp.res;
            if (i_r == 4'd3) begin
              state_r <= S_CHK;
            end else begin
              i_r     <= i_r + 4'd1;
              state_r <= S_DRD;
            end
          end
        end
        S_CHK: state_r <= (acc_r[30:0] == '0) ? S_SING : S_RCPW;
        S_SING: begin
          if (out_free) begin
            out_bits_r  <= '0;
            out_idx_r   <= '0;
            out_sing_r  <= 1'b1;
            out_last_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_RCPW: begin
          if (fpu_rsp.done) begin
            rcp_r   <= fpu_rsp.res;
            i_r     <= '0;
            state_r <= S_ORD;
          end
        end
        // scale each cofactor by the reciprocal
        S_ORD: state_r <= S_OLD;
        S_OLD: begin
          op_a_r  <= cof_rd_r;
          op_b_r  <= rcp_r;
          state_r <= S_OMS;
        end
        S_OMS: state_r <= S_OMW;
        S_OMW: begin
          if (fpu_rsp.done) begin
            op_a_r  <= fpu_rsp.res;
            state_r <= S_OPUSH;
          end
        end
        S_OPUSH: begin
          if (out_free) begin
            out_bits_r  <= op_a_r;
            out_idx_r   <= i_r;
            out_sing_r  <= 1'b0;
            out_last_r  <= (i_r == m4i_pkg::MAT_LAST);
            if (i_r == m4i_pkg::MAT_LAST) begin
              state_r <= S_IDLE;
            end else begin
              i_r     <= i_r + 4'd1;
              state_r <= S_ORD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_bits  = out_bits_r;
  assign out_ch.result_index = out_idx_r;
  assign out_ch.singular     = out_sing_r;
  assign out_ch.last         = out_last_r;

  // checks
  a_sing_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.singular |-> out_ch.last && (out_ch.result_bits == '0))
    else $error("singular item not final or not zero");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.last && !out_ch.singular |->
      out_ch.result_index == m4i_pkg::MAT_LAST)
    else $error("final item carries wrong index");

  a_fpu_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !fpu_rsp.busy && !fpu_rsp.done)
    else $error("float unit active while sequencer idle");

  a_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    fpu_rsp.done |-> (state_r == S_M1W) || (state_r == S_M2W) || (state_r == S_ADW) ||
      (state_r == S_DMW) || (state_r == S_DAW) || (state_r == S_RCPW) ||
      (state_r == S_OMW))
    else $error("float result arrived outside a wait state");

endmodule
`default_nettype wire
